@@ rtl/tfd_pkg.sv @@
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared constants for the timestamped frame deframer: frame marker words,
// word class codes, register indexes, reset values, parameter defaults and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tfd_pkg;

  // field widths
  localparam int WORD_W      = 16;
  localparam int CLASS_W     = 3;
  localparam int INDEX_W     = 18;
  localparam int TS_W        = 60;
  localparam int TS_CHUNK_W  = 15;
  localparam int STAT_W      = 32;
  localparam int CHAN_REG_W  = 7;
  localparam int SPF_REG_W   = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;

  // frame marker words
  localparam logic [WORD_W-1:0] START_WORD = 16'h0001;
  localparam logic [WORD_W-1:0] END_WORD   = 16'hFFFE;

  // word class codes
  localparam logic [CLASS_W-1:0] CLS_SKIP    = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_START   = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_TS      = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_PAYLOAD = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_END_OK  = 3'd4;
  localparam logic [CLASS_W-1:0] CLS_END_BAD = 3'd5;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES_PER_FRAME = 2'd1;

  // register reset values
  localparam logic [CHAN_REG_W-1:0] CHANNEL_COUNT_RST     = 7'd1;
  localparam logic [SPF_REG_W-1:0]  SAMPLES_PER_FRAME_RST = 13'd64;

  // parameter defaults
  localparam int MAX_CHANNELS_DEF = 64;
  localparam int MAX_SAMPLES_DEF  = 4096;
  localparam int COUNT_WIDTH_DEF  = 32;

endpackage

`default_nettype wire

@@ rtl/timestamped_frame_deframer_top.sv @@
// ----------------------------------------------------------------------------
// timestamped_frame_deframer_top
// Results are registered: a result is valid in the cycle after its input transfer.
// Throughput: one word per cycle; the single result register decouples the
// two sides, and the input stalls only in reset or while a result waits to be taken.
// Reset (rst, synchronous): hunting for start, counters and timestamps zero,
// channel_count 1, samples_per_frame 64, no result pending.
// Splits a word stream into frames: start word, four 15-bit timestamp words,
// channel_count * samples_per_frame payload words, end word. Every word gives
// one classified result plus saturating status counters.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamped_frame_deframer_top #(
  parameter int MAX_CHANNELS = tfd_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_SAMPLES  = tfd_pkg::MAX_SAMPLES_DEF,
  parameter int COUNT_WIDTH  = tfd_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration writes
  input  wire logic                             cfg_we,
  input  wire logic [tfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [tfd_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input words
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [tfd_pkg::WORD_W-1:0]       word,
  // results
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [tfd_pkg::CLASS_W-1:0]           word_class,
  output logic [tfd_pkg::WORD_W-1:0]            payload_word,
  output logic [tfd_pkg::INDEX_W-1:0]           payload_index,
  output logic                                  payload_last,
  output logic [tfd_pkg::TS_W-1:0]              frame_timestamp,
  output logic                                  timestamp_mismatch,
  output logic [tfd_pkg::STAT_W-1:0]            good_frames,
  output logic [tfd_pkg::STAT_W-1:0]            bad_frames,
  output logic [tfd_pkg::STAT_W-1:0]            timestamp_errors,
  output logic [tfd_pkg::STAT_W-1:0]            skipped_words,
  output logic [tfd_pkg::STAT_W-1:0]            total_words
);

  localparam int CW     = COUNT_WIDTH;
  localparam int CHW    = tfd_pkg::CHAN_REG_W;
  localparam int SPW    = tfd_pkg::SPF_REG_W;
  localparam int LENW   = CHW + SPW;
  localparam int TSW    = tfd_pkg::TS_W;
  localparam int CKW    = tfd_pkg::TS_CHUNK_W;
  localparam int IDXW   = tfd_pkg::INDEX_W;
  localparam int STW    = tfd_pkg::STAT_W;
  // clamp limits, bounded by what the register fields can hold
  localparam int ChanLimI = (MAX_CHANNELS < (2 ** CHW) - 1) ? MAX_CHANNELS : (2 ** CHW) - 1;
  localparam int SpfLimI  = (MAX_SAMPLES < (2 ** SPW) - 1) ? MAX_SAMPLES : (2 ** SPW) - 1;
  localparam logic [CHW-1:0] CHAN_LIM = CHW'(ChanLimI);
  localparam logic [SPW-1:0] SPF_LIM  = SPW'(SpfLimI);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TS0,
    PH_TS1,
    PH_TS2,
    PH_TS3,
    PH_PAY,
    PH_END
  } phase_t;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic logic [STW-1:0] stat_view(input logic [CW-1:0] c);
    logic [CW+STW-1:0] ext;
    ext = {{STW{1'b0}}, c};
    return ext[STW-1:0];
  endfunction

  // configuration registers
  logic [CHW-1:0] channel_count;
  logic [SPW-1:0] samples_per_frame;

  // frame state
  phase_t          phase, phase_next;
  logic [IDXW-1:0] pay_pos, pay_pos_next;
  logic [TSW-1:0]  ts_acc, ts_acc_next;
  logic [TSW:0]    exp_ts, exp_ts_next;
  logic [CW-1:0]   good_cnt, good_cnt_next;
  logic [CW-1:0]   bad_cnt, bad_cnt_next;
  logic [CW-1:0]   ts_err_cnt, ts_err_cnt_next;
  logic [CW-1:0]   skip_cnt, skip_cnt_next;
  logic [CW-1:0]   word_cnt, word_cnt_next;

  // per-word result
  logic [tfd_pkg::CLASS_W-1:0] cls;
  logic [tfd_pkg::WORD_W-1:0]  pword;
  logic [IDXW-1:0]             pidx;
  logic                        plast;
  logic                        mism;

  logic            accept;
  logic [CHW-1:0]  chans;
  logic [SPW-1:0]  spf;
  logic [LENW-1:0] pay_len;
  logic [CKW-1:0]  bits;

  // no input transfer while in reset
  assign in_ready = !rst && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign bits     = word[CKW-1:0];

  // clamp the registers into range and form the payload length
  always_comb begin
    chans   = (channel_count == '0) ? CHW'(1) :
              ((channel_count > CHAN_LIM) ? CHAN_LIM : channel_count);
    spf     = (samples_per_frame == '0) ? SPW'(1) :
              ((samples_per_frame > SPF_LIM) ? SPF_LIM : samples_per_frame);
    pay_len = LENW'(chans) * LENW'(spf);
  end

  // frame parser, one word per transfer
  always_comb begin
    phase_next      = phase;
    pay_pos_next    = pay_pos;
    ts_acc_next     = ts_acc;
    exp_ts_next     = exp_ts;
    good_cnt_next   = good_cnt;
    bad_cnt_next    = bad_cnt;
    ts_err_cnt_next = ts_err_cnt;
    skip_cnt_next   = skip_cnt;
    word_cnt_next   = sat_inc(word_cnt);
    cls             = tfd_pkg::CLS_SKIP;
    pword           = '0;
    pidx            = '0;
    plast           = 1'b0;
    mism            = 1'b0;

    unique case (phase)
      PH_HUNT: begin
        if (word == tfd_pkg::START_WORD) begin
          cls           = tfd_pkg::CLS_START;
          skip_cnt_next = '0;
          phase_next    = PH_TS0;
        end else begin
          skip_cnt_next = sat_inc(skip_cnt);
        end
      end
      PH_TS0: begin
        cls         = tfd_pkg::CLS_TS;
        ts_acc_next = {{(TSW-CKW){1'b0}}, bits};
        phase_next  = PH_TS1;
      end
      PH_TS1: begin
        cls         = tfd_pkg::CLS_TS;
        ts_acc_next = ts_acc | {{(TSW-2*CKW){1'b0}}, bits, {CKW{1'b0}}};
        phase_next  = PH_TS2;
      end
      PH_TS2: begin
        cls         = tfd_pkg::CLS_TS;
        ts_acc_next = ts_acc | {{(TSW-3*CKW){1'b0}}, bits, {(2*CKW){1'b0}}};
        phase_next  = PH_TS3;
      end
      PH_TS3: begin
        cls         = tfd_pkg::CLS_TS;
        ts_acc_next = ts_acc | {bits, {(3*CKW){1'b0}}};
        // continuity check, skipped until the first frame has set a target
        if (exp_ts != '0 && {1'b0, ts_acc_next} != exp_ts) begin
          mism            = 1'b1;
          ts_err_cnt_next = sat_inc(ts_err_cnt);
        end
        exp_ts_next  = {1'b0, ts_acc_next} + (TSW+1)'(spf);
        pay_pos_next = '0;
        phase_next   = PH_PAY;
      end
      PH_PAY: begin
        cls   = tfd_pkg::CLS_PAYLOAD;
        pword = word;
        pidx  = pay_pos;
        // length is re-evaluated every word so register changes take effect
        if ((LENW'(pay_pos) + LENW'(1)) >= pay_len) begin
          plast        = 1'b1;
          pay_pos_next = '0;
          phase_next   = PH_END;
        end else begin
          pay_pos_next = pay_pos + 1'b1;
        end
      end
      PH_END: begin
        if (word == tfd_pkg::END_WORD) begin
          cls           = tfd_pkg::CLS_END_OK;
          good_cnt_next = sat_inc(good_cnt);
        end else begin
          cls          = tfd_pkg::CLS_END_BAD;
          bad_cnt_next = sat_inc(bad_cnt);
        end
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count     <= tfd_pkg::CHANNEL_COUNT_RST;
      samples_per_frame <= tfd_pkg::SAMPLES_PER_FRAME_RST;
    end else if (cfg_we) begin
      if (cfg_index == tfd_pkg::REG_CHANNEL_COUNT) begin
        channel_count <= cfg_data[CHW-1:0];
      end
      if (cfg_index == tfd_pkg::REG_SAMPLES_PER_FRAME) begin
        samples_per_frame <= cfg_data[SPW-1:0];
      end
    end
  end

  // frame state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      pay_pos    <= '0;
      ts_acc     <= '0;
      exp_ts     <= '0;
      good_cnt   <= '0;
      bad_cnt    <= '0;
      ts_err_cnt <= '0;
      skip_cnt   <= '0;
      word_cnt   <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      pay_pos    <= pay_pos_next;
      ts_acc     <= ts_acc_next;
      exp_ts     <= exp_ts_next;
      good_cnt   <= good_cnt_next;
      bad_cnt    <= bad_cnt_next;
      ts_err_cnt <= ts_err_cnt_next;
      skip_cnt   <= skip_cnt_next;
      word_cnt   <= word_cnt_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      word_class         <= cls;
      payload_word       <= pword;
      payload_index      <= pidx;
      payload_last       <= plast;
      frame_timestamp    <= ts_acc_next;
      timestamp_mismatch <= mism;
      good_frames        <= stat_view(good_cnt_next);
      bad_frames         <= stat_view(bad_cnt_next);
      timestamp_errors   <= stat_view(ts_err_cnt_next);
      skipped_words      <= stat_view(skip_cnt_next);
      total_words        <= stat_view(word_cnt_next);
    end
  end

  // a last payload flag only ever rides on a payload result
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && payload_last) |-> (word_class == tfd_pkg::CLS_PAYLOAD))
    else $error("payload_last set on a non-payload result");

  // a timestamp mismatch only ever rides on a timestamp result
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && timestamp_mismatch) |-> (word_class == tfd_pkg::CLS_TS))
    else $error("timestamp_mismatch set on a non-timestamp result");

  // any accepted word leaves a pending result with a nonzero word count
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_valid && total_words != '0))
    else $error("accepted word did not produce a counted result");

  // an end word always returns the parser to hunting
  assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_END) |=> (phase == PH_HUNT))
    else $error("parser did not resume hunting after end word");

  // the final payload word always moves the parser to the end word
  assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_PAY && plast) |=> (phase == PH_END && pay_pos == '0))
    else $error("payload did not close correctly");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timestamped frame deframer. Framed word streams
// (good frames, timestamp jumps, bad end words, cut payloads, noise) are fed
// through the input channel under random idling and stalls, across several
// register settings. A word-level tracker of the deframer predicts the
// classified result of every word, and each result transfer is checked
// against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_CHANS   = tfd_pkg::MAX_CHANNELS_DEF;
  localparam int MAX_SPF     = tfd_pkg::MAX_SAMPLES_DEF;

  // index values that map to no register
  localparam logic [tfd_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [tfd_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic [2:0] {
    PH_HUNT, PH_TS0, PH_TS1, PH_TS2, PH_TS3, PH_PAYLOAD, PH_END
  } frame_phase_t;

  typedef struct packed {
    logic [tfd_pkg::CLASS_W-1:0] word_class;
    logic [tfd_pkg::WORD_W-1:0]  payload_word;
    logic [tfd_pkg::INDEX_W-1:0] payload_index;
    logic                        payload_last;
    logic [tfd_pkg::TS_W-1:0]    frame_ts;
    logic                        ts_mismatch;
    logic [tfd_pkg::STAT_W-1:0]  good_cnt;
    logic [tfd_pkg::STAT_W-1:0]  bad_cnt;
    logic [tfd_pkg::STAT_W-1:0]  ts_err_cnt;
    logic [tfd_pkg::STAT_W-1:0]  skip_cnt;
    logic [tfd_pkg::STAT_W-1:0]  word_cnt;
  } word_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            cfg_we    = 1'b0;
  logic [tfd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [tfd_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [tfd_pkg::WORD_W-1:0] word     = '0;

  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [tfd_pkg::CLASS_W-1:0] word_class;
  logic [tfd_pkg::WORD_W-1:0]  payload_word;
  logic [tfd_pkg::INDEX_W-1:0] payload_index;
  logic                        payload_last;
  logic [tfd_pkg::TS_W-1:0]    frame_timestamp;
  logic                        timestamp_mismatch;
  logic [tfd_pkg::STAT_W-1:0]  good_frames;
  logic [tfd_pkg::STAT_W-1:0]  bad_frames;
  logic [tfd_pkg::STAT_W-1:0]  timestamp_errors;
  logic [tfd_pkg::STAT_W-1:0]  skipped_words;
  logic [tfd_pkg::STAT_W-1:0]  total_words;

  timestamped_frame_deframer_top dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .word               (word),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .word_class         (word_class),
    .payload_word       (payload_word),
    .payload_index      (payload_index),
    .payload_last       (payload_last),
    .frame_timestamp    (frame_timestamp),
    .timestamp_mismatch (timestamp_mismatch),
    .good_frames        (good_frames),
    .bad_frames         (bad_frames),
    .timestamp_errors   (timestamp_errors),
    .skipped_words      (skipped_words),
    .total_words        (total_words)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // words waiting to be sent, and deframed results waiting to come back
  logic [tfd_pkg::WORD_W-1:0] word_stream_q [$];
  logic [tfd_pkg::WORD_W-1:0] staged_q [$];
  word_result_t               deframed_q [$];

  int unsigned send_idle_pct = 7;
  int unsigned stall_pct     = 73;
  int unsigned mismatches    = 0;
  int unsigned cycles        = 0;

  // tracked deframer state and registers
  frame_phase_t                   trk_phase;
  logic [tfd_pkg::INDEX_W-1:0]    trk_pos;
  logic [tfd_pkg::TS_W-1:0]       trk_ts;
  logic [tfd_pkg::TS_W:0]         trk_next_ts;
  logic [tfd_pkg::STAT_W-1:0]     trk_good, trk_bad, trk_ts_err, trk_skip, trk_words;
  logic [tfd_pkg::CHAN_REG_W-1:0] trk_chan;
  logic [tfd_pkg::SPF_REG_W-1:0]  trk_spf;

  // stream generator view of the settings
  int unsigned              gen_spf_eff;
  int unsigned              gen_len;
  int unsigned              stage_cap;
  logic [tfd_pkg::TS_W-1:0] gen_next_ts;

  word_result_t got_result, want_result;

  function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [tfd_pkg::STAT_W-1:0] sat_inc(logic [tfd_pkg::STAT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // advance the tracked deframer by one word and return its result
  function automatic word_result_t deframe_word(logic [tfd_pkg::WORD_W-1:0] w);
    word_result_t r;
    logic [tfd_pkg::TS_W-1:0] chunk;
    int unsigned chans, spf, len;
    r     = '0;
    chunk = tfd_pkg::TS_W'(w[tfd_pkg::TS_CHUNK_W-1:0]);
    chans = clamp_reg(trk_chan, MAX_CHANS);
    spf   = clamp_reg(trk_spf, MAX_SPF);
    trk_words = sat_inc(trk_words);
    case (trk_phase)
      PH_HUNT: begin
        if (w == tfd_pkg::START_WORD) begin
          r.word_class = tfd_pkg::CLS_START;
          trk_skip     = '0;
          trk_phase    = PH_TS0;
        end else begin
          r.word_class = tfd_pkg::CLS_SKIP;
          trk_skip     = sat_inc(trk_skip);
        end
      end
      PH_TS0: begin
        r.word_class = tfd_pkg::CLS_TS;
        trk_ts       = chunk;
        trk_phase    = PH_TS1;
      end
      PH_TS1: begin
        r.word_class = tfd_pkg::CLS_TS;
        trk_ts       = trk_ts | (chunk << tfd_pkg::TS_CHUNK_W);
        trk_phase    = PH_TS2;
      end
      PH_TS2: begin
        r.word_class = tfd_pkg::CLS_TS;
        trk_ts       = trk_ts | (chunk << (2 * tfd_pkg::TS_CHUNK_W));
        trk_phase    = PH_TS3;
      end
      PH_TS3: begin
        r.word_class = tfd_pkg::CLS_TS;
        trk_ts       = trk_ts | (chunk << (3 * tfd_pkg::TS_CHUNK_W));
        // continuity check only once a previous timestamp exists
        if (trk_next_ts != '0 && {1'b0, trk_ts} != trk_next_ts) begin
          r.ts_mismatch = 1'b1;
          trk_ts_err    = sat_inc(trk_ts_err);
        end
        trk_next_ts = {1'b0, trk_ts} + (tfd_pkg::TS_W+1)'(spf);
        trk_pos     = '0;
        trk_phase   = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        // length follows the current registers on every word
        len             = chans * spf;
        r.word_class    = tfd_pkg::CLS_PAYLOAD;
        r.payload_word  = w;
        r.payload_index = trk_pos;
        if (int'(trk_pos) + 1 >= int'(len)) begin
          r.payload_last = 1'b1;
          trk_pos        = '0;
          trk_phase      = PH_END;
        end else begin
          trk_pos = trk_pos + 1'b1;
        end
      end
      PH_END: begin
        if (w == tfd_pkg::END_WORD) begin
          r.word_class = tfd_pkg::CLS_END_OK;
          trk_good     = sat_inc(trk_good);
        end else begin
          r.word_class = tfd_pkg::CLS_END_BAD;
          trk_bad      = sat_inc(trk_bad);
        end
        trk_phase = PH_HUNT;
      end
      default: trk_phase = PH_HUNT;
    endcase
    r.frame_ts   = trk_ts;
    r.good_cnt   = trk_good;
    r.bad_cnt    = trk_bad;
    r.ts_err_cnt = trk_ts_err;
    r.skip_cnt   = trk_skip;
    r.word_cnt   = trk_words;
    return r;
  endfunction

  function automatic string fmt_result(word_result_t r);
    return {$sformatf("class %0d word %h index %0d last %0b ts %h ts_mis %0b ",
                      r.word_class, r.payload_word, r.payload_index, r.payload_last,
                      r.frame_ts, r.ts_mismatch),
            $sformatf("good %0d bad %0d ts_err %0d skip %0d total %0d",
                      r.good_cnt, r.bad_cnt, r.ts_err_cnt, r.skip_cnt, r.word_cnt)};
  endfunction

  // input driver: tracks registers, predicts on each word transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      trk_phase   = PH_HUNT;
      trk_pos     = '0;
      trk_ts      = '0;
      trk_next_ts = '0;
      trk_good    = '0;
      trk_bad     = '0;
      trk_ts_err  = '0;
      trk_skip    = '0;
      trk_words   = '0;
      trk_chan    = tfd_pkg::CHANNEL_COUNT_RST;
      trk_spf     = tfd_pkg::SAMPLES_PER_FRAME_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tfd_pkg::REG_CHANNEL_COUNT:
            trk_chan = cfg_data[tfd_pkg::CHAN_REG_W-1:0];
          tfd_pkg::REG_SAMPLES_PER_FRAME:
            trk_spf  = cfg_data[tfd_pkg::SPF_REG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        deframed_q.push_back(deframe_word(word));
      if (!in_valid || in_ready) begin
        if (word_stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          word     <= word_stream_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_result = {word_class, payload_word, payload_index, payload_last,
                      frame_timestamp, timestamp_mismatch, good_frames, bad_frames,
                      timestamp_errors, skipped_words, total_words};
        if (deframed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: %s", fmt_result(got_result));
        end else begin
          want_result = deframed_q.pop_front();
          if (got_result !== want_result) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch");
              $display("  expected %s", fmt_result(want_result));
              $display("  actual   %s", fmt_result(got_result));
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(logic [tfd_pkg::CFG_INDEX_W-1:0] idx,
                           logic [tfd_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // channel writes carry random junk above the register width
  task automatic set_config(int unsigned chan, int unsigned spf);
    write_reg(tfd_pkg::REG_CHANNEL_COUNT, {6'($urandom_range(63)), 7'(chan)});
    write_reg(tfd_pkg::REG_SAMPLES_PER_FRAME, 13'(spf));
    gen_spf_eff = clamp_reg(chan & 32'h7F, MAX_CHANS) == 0 ? 1 : clamp_reg(spf, MAX_SPF);
    gen_len     = clamp_reg(chan & 32'h7F, MAX_CHANS) * gen_spf_eff;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (word_stream_q.size() != 0 || in_valid || deframed_q.size() != 0);
  endtask

  // hunting noise that never holds a start word
  task automatic put_noise(int unsigned n);
    logic [tfd_pkg::WORD_W-1:0] w;
    repeat (n) begin
      w = tfd_pkg::WORD_W'($urandom_range(65535));
      if (w == tfd_pkg::START_WORD) w = tfd_pkg::END_WORD;
      staged_q.push_back(w);
    end
  endtask

  task automatic put_frame(logic [tfd_pkg::TS_W-1:0] ts, int unsigned len, bit end_ok);
    logic [tfd_pkg::WORD_W-1:0] w;
    staged_q.push_back(tfd_pkg::START_WORD);
    for (int i = 0; i < 4; i++)
      staged_q.push_back({1'($urandom_range(1)),
                          ts[i*tfd_pkg::TS_CHUNK_W +: tfd_pkg::TS_CHUNK_W]});
    for (int unsigned i = 0; i < len && staged_q.size() < stage_cap; i++)
      staged_q.push_back(tfd_pkg::WORD_W'($urandom_range(65535)));
    if (end_ok) begin
      staged_q.push_back(tfd_pkg::END_WORD);
    end else begin
      w = ($urandom_range(3) == 0) ? tfd_pkg::START_WORD :
                                     tfd_pkg::WORD_W'($urandom_range(65535));
      if (w == tfd_pkg::END_WORD) w = '0;
      staged_q.push_back(w);
    end
  endtask

  // mostly well-formed frames; some jumps, bad ends, cut payloads and noise
  task automatic build_random_phase(int unsigned target);
    int unsigned kind, len;
    logic [tfd_pkg::TS_W-1:0] ts;
    staged_q.delete();
    stage_cap = target;
    while (staged_q.size() < target) begin
      if ($urandom_range(99) < 30) put_noise($urandom_range(1, 2));
      kind = $urandom_range(99);
      ts   = gen_next_ts;
      len  = gen_len;
      if (kind >= 70 && kind < 80) ts = tfd_pkg::TS_W'({$urandom, $urandom});
      if (kind >= 88 && kind < 94 && len > 1) len = $urandom_range(len - 1);
      if (kind >= 94) begin
        put_noise($urandom_range(1, 4));
      end else begin
        put_frame(ts, len, !(kind >= 80 && kind < 88));
        gen_next_ts = ts + tfd_pkg::TS_W'(gen_spf_eff);
      end
    end
    while (staged_q.size() > target) void'(staged_q.pop_back());
  endtask

  // stimulus sequencing
  initial begin
    int unsigned chan, spf, target;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: word extremes, max and zero timestamps, marker words as payload,
    // a start word as bad end word
    set_config(1, 2);
    @(negedge clk);
    word_stream_q = '{16'h0000, 16'hFFFF, tfd_pkg::END_WORD,
                      tfd_pkg::START_WORD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'h0000, tfd_pkg::END_WORD,
                      tfd_pkg::START_WORD, 16'h8000, 16'h0000, 16'h8000, 16'h0000,
                      tfd_pkg::START_WORD, tfd_pkg::END_WORD, tfd_pkg::START_WORD,
                      16'h1234, tfd_pkg::START_WORD};
    wait_drained();

    gen_next_ts = tfd_pkg::TS_W'({$urandom, $urandom});
    for (int k = 0; k < 12; k++) begin
      target = 60;
      case (k)
        0:  begin chan = 2;   spf = 3;    end
        1:  begin chan = 0;   spf = 0;    end
        2:  begin chan = 64;  spf = 1;    target = 80; end
        3:  begin chan = 1;   spf = 8191; target = 30; end
        4:  begin chan = 3;   spf = 2;    end
        5:  begin chan = 127; spf = 2;    target = 40; end
        6:  begin chan = 1;   spf = 4;    end
        7:  begin chan = 4;   spf = 1;    end
        8:  begin chan = 64;  spf = 4096; target = 35; end
        9:  begin chan = 1;   spf = 2;    end
        10: begin chan = $urandom_range(1, 4); spf = $urandom_range(1, 6); end
        default: begin chan = 1; spf = 1; end
      endcase
      if (k < 4) begin
        send_idle_pct = 7;
        stall_pct     = 73;
      end else if (k < 8) begin
        send_idle_pct = 73;
        stall_pct     = 7;
      end else begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      set_config(chan, spf);
      if (k == 7) begin
        write_reg(REG_SPARE_A, 13'($urandom_range(8191)));
        write_reg(REG_SPARE_B, 13'($urandom_range(8191)));
      end
      build_random_phase(target);
      @(negedge clk);
      word_stream_q = staged_q;
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tfd_pkg.sv
rtl/timestamped_frame_deframer_top.sv
sim/testbench.sv
